### rtl/rayobb_pkg.sv
package rayobb_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int AXIS_BITS      = 16;
    localparam int REG_W          = 48;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_U      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_V      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_W      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_EXTENTS = 3'd4;

    localparam logic [REG_W-1:0] RST_BOX_CENTER  = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] RST_AXIS_U      = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] RST_AXIS_V      = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] RST_AXIS_W      = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] RST_BOX_EXTENTS = 48'h0000_0000_0000;

endpackage

### rtl/ray_obb_overlap_test.sv
// Ray versus oriented box hit test, six register stages.
// o_valid and o_hit are registered outputs of the last stage, stage 6.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset (synchronous, active low) clears the stage valid bits and returns the
// box registers to center 0, axes (1,0,0) (0,1,0) (0,0,1), extents 0.
// The receiver cannot stall: each result shows for exactly one cycle.
module ray_obb_overlap_test #(
    parameter int COORD_BITS = rayobb_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_origin_x,
    input  logic signed [COORD_BITS-1:0]        i_origin_y,
    input  logic signed [COORD_BITS-1:0]        i_origin_z,
    input  logic signed [rayobb_pkg::AXIS_BITS-1:0] i_dir_x,
    input  logic signed [rayobb_pkg::AXIS_BITS-1:0] i_dir_y,
    input  logic signed [rayobb_pkg::AXIS_BITS-1:0] i_dir_z,
    output logic                                o_valid,
    output logic                                o_hit,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rayobb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rayobb_pkg::REG_W-1:0]        i_cfg_data
);

    localparam int AB     = rayobb_pkg::AXIS_BITS;
    localparam int PACK_W = 3 * COORD_BITS;
    localparam int APK_W  = 3 * AB;
    localparam int DW     = COORD_BITS + 1;
    localparam int WP_W   = 2 * AB;
    localparam int WD_W   = WP_W + 2;
    localparam int DP_W   = DW + AB;
    localparam int DD_W   = DP_W + 2;
    localparam int CP_W   = DW + AB;
    localparam int CR_W   = CP_W + 1;
    localparam int CQ_W   = CR_W + AB;
    localparam int CD_W   = CQ_W + 2;
    localparam int EP_W   = COORD_BITS + WD_W;
    localparam int LIM_W  = EP_W + 1;
    localparam int SLAB_SH = AB - 2;

    logic [rayobb_pkg::REG_W-1:0] r_center, r_axis_u, r_axis_v, r_axis_w, r_extents;

    logic signed [AB-1:0]         ax [3][3];
    logic signed [COORD_BITS-1:0] ctr [3];
    logic [COORD_BITS-1:0]        ext [3];
    logic [PACK_W-1:0]            ctr_pk, ext_pk;
    logic [APK_W-1:0]             axu_pk, axv_pk, axw_pk;

    logic [5:0] r_vld;

    logic signed [DW-1:0]   r1_diff [3];
    logic signed [AB-1:0]   r1_dir  [3];
    logic signed [WP_W-1:0] r2_wp [3][3];
    logic signed [DP_W-1:0] r2_dp [3][3];
    logic signed [CP_W-1:0] r2_cp [6];
    logic signed [WD_W-1:0] r3_wd [3];
    logic signed [DD_W-1:0] r3_dd [3];
    logic signed [CR_W-1:0] r3_cr [3];
    logic [2:0]             r4_slab;
    logic signed [CQ_W-1:0] r4_cq [3][3];
    logic [EP_W-1:0]        r4_ep [6];
    logic [2:0]             r5_slab;
    logic signed [CD_W-1:0] r5_cd [3];
    logic [LIM_W-1:0]       r5_lim [3];
    logic                   r6_hit;

    logic signed [DW-1:0]   n1_diff [3];
    logic [2:0]             n4_slab;
    logic [WD_W-1:0]        awd [3];
    logic                   n6_hit;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[5];
    assign o_hit       = r6_hit;

    always_comb begin
        ctr_pk = PACK_W'(r_center);
        ext_pk = PACK_W'(r_extents);
        axu_pk = APK_W'(r_axis_u);
        axv_pk = APK_W'(r_axis_v);
        axw_pk = APK_W'(r_axis_w);
        for (int i = 0; i < 3; i++) begin
            ctr[i]   = ctr_pk[i*COORD_BITS +: COORD_BITS];
            ext[i]   = ext_pk[i*COORD_BITS +: COORD_BITS];
            ax[0][i] = axu_pk[i*AB +: AB];
            ax[1][i] = axv_pk[i*AB +: AB];
            ax[2][i] = axw_pk[i*AB +: AB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center  <= rayobb_pkg::RST_BOX_CENTER;
            r_axis_u  <= rayobb_pkg::RST_AXIS_U;
            r_axis_v  <= rayobb_pkg::RST_AXIS_V;
            r_axis_w  <= rayobb_pkg::RST_AXIS_W;
            r_extents <= rayobb_pkg::RST_BOX_EXTENTS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rayobb_pkg::REG_BOX_CENTER:  r_center  <= i_cfg_data;
                rayobb_pkg::REG_AXIS_U:      r_axis_u  <= i_cfg_data;
                rayobb_pkg::REG_AXIS_V:      r_axis_v  <= i_cfg_data;
                rayobb_pkg::REG_AXIS_W:      r_axis_w  <= i_cfg_data;
                rayobb_pkg::REG_BOX_EXTENTS: r_extents <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], start && !busy};
        end
    end

    always_comb begin
        n1_diff[0] = DW'(i_origin_x) - DW'(ctr[0]);
        n1_diff[1] = DW'(i_origin_y) - DW'(ctr[1]);
        n1_diff[2] = DW'(i_origin_z) - DW'(ctr[2]);
    end

    // slab reject: outside the slab and pointing away (zero counts as away)
    always_comb begin
        logic [DD_W-1:0] add;
        logic [DD_W-1:0] lim;
        logic            away;
        for (int i = 0; i < 3; i++) begin
            awd[i] = r3_wd[i][WD_W-1] ? -r3_wd[i] : r3_wd[i];
            add    = r3_dd[i][DD_W-1] ? -r3_dd[i] : r3_dd[i];
            lim    = DD_W'(ext[i]) << SLAB_SH;
            away   = (r3_dd[i] == '0) || (r3_wd[i] == '0) ||
                     (r3_dd[i][DD_W-1] == r3_wd[i][WD_W-1]);
            n4_slab[i] = (add > lim) && away;
        end
    end

    always_comb begin
        logic [CD_W-1:0] acd;
        logic            sep;
        sep = |r5_slab;
        for (int i = 0; i < 3; i++) begin
            acd = r5_cd[i][CD_W-1] ? -r5_cd[i] : r5_cd[i];
            if (acd > CD_W'(r5_lim[i])) begin
                sep = 1'b1;
            end
        end
        n6_hit = !sep;
    end

    always_ff @(posedge i_clk) begin
        // stage 1: offset from center
        for (int i = 0; i < 3; i++) begin
            r1_diff[i] <= n1_diff[i];
        end
        r1_dir[0] <= i_dir_x;
        r1_dir[1] <= i_dir_y;
        r1_dir[2] <= i_dir_z;

        // stage 2: dot and cross partial products
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r2_wp[i][j] <= WP_W'(r1_dir[j] * ax[i][j]);
                r2_dp[i][j] <= DP_W'(r1_diff[j] * ax[i][j]);
            end
        end
        r2_cp[0] <= CP_W'(r1_dir[1] * r1_diff[2]);
        r2_cp[1] <= CP_W'(r1_dir[2] * r1_diff[1]);
        r2_cp[2] <= CP_W'(r1_dir[2] * r1_diff[0]);
        r2_cp[3] <= CP_W'(r1_dir[0] * r1_diff[2]);
        r2_cp[4] <= CP_W'(r1_dir[0] * r1_diff[1]);
        r2_cp[5] <= CP_W'(r1_dir[1] * r1_diff[0]);

        // stage 3: sums
        for (int i = 0; i < 3; i++) begin
            r3_wd[i] <= WD_W'(r2_wp[i][0]) + WD_W'(r2_wp[i][1]) + WD_W'(r2_wp[i][2]);
            r3_dd[i] <= DD_W'(r2_dp[i][0]) + DD_W'(r2_dp[i][1]) + DD_W'(r2_dp[i][2]);
            r3_cr[i] <= CR_W'(r2_cp[2*i]) - CR_W'(r2_cp[2*i+1]);
        end

        // stage 4: slab decision, cross-axis and extent products
        r4_slab <= n4_slab;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r4_cq[i][j] <= CQ_W'(r3_cr[j] * ax[i][j]);
            end
        end
        r4_ep[0] <= EP_W'(ext[1] * awd[2]);
        r4_ep[1] <= EP_W'(ext[2] * awd[1]);
        r4_ep[2] <= EP_W'(ext[0] * awd[2]);
        r4_ep[3] <= EP_W'(ext[2] * awd[0]);
        r4_ep[4] <= EP_W'(ext[0] * awd[1]);
        r4_ep[5] <= EP_W'(ext[1] * awd[0]);

        // stage 5: projected cross term and limit
        r5_slab <= r4_slab;
        for (int i = 0; i < 3; i++) begin
            r5_cd[i]  <= CD_W'(r4_cq[i][0]) + CD_W'(r4_cq[i][1]) + CD_W'(r4_cq[i][2]);
            r5_lim[i] <= LIM_W'(r4_ep[2*i]) + LIM_W'(r4_ep[2*i+1]);
        end

        // stage 6: final decision
        r6_hit <= n6_hit;
    end

endmodule
